/* rtl/msdq_pkg.sv */
`timescale 1ns / 1ps
package msdq_pkg;

   localparam int SLOT_COUNT_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int MAX_PAYLOAD_DEF = 2048;

   localparam logic [1:0] KIND_DEPOSIT = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SLOT  = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  slot;
      logic [31:0] src_ip;
      logic [15:0] sender_port;
      logic [7:0]  data_byte;
      logic        has_byte;
      logic        first;
      logic        last;
      logic [15:0] max_len;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_ip;
      logic [15:0] out_port;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        end_of_read;
      logic [11:0] delivered_len;
      logic [3:0]  pending;
   } rsp_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

endpackage

/* rtl/multi_slot_datagram_queue.sv */
`timescale 1ns / 1ps
// A word is answered from the execute state that follows acceptance; the memories are read at the
// accepting edge and the result register loads at the end of the execute cycle.
// A new word is not accepted during the execute cycle; the header and payload memories are written back
// in the execute cycle before the next word enters. A result not yet taken holds off input.
// Reset: synchronous, clears queue indexes, counts and open deposit/read state at once;
// memory contents are not cleared and are only used after being written.
module multi_slot_datagram_queue
   import msdq_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);
   localparam int LW   = $clog2(MAX_PAYLOAD + 1);
   localparam int HN   = SLOT_COUNT * QUEUE_DEPTH;
   localparam int HAW  = (HN > 1) ? $clog2(HN) : 1;
   localparam int PN   = HN * MAX_PAYLOAD;
   localparam int PAW  = (PN > 1) ? $clog2(PN) : 1;
   localparam int HDW  = 48 + LW;

   logic [HDW-1:0] hdr_mem [HN];
   logic [7:0]     pay_mem [PN];
   logic [HDW-1:0] hdr_rd_ff;
   logic [7:0]     pay_rd_ff;

   logic [QW-1:0]  head_ff [SLOT_COUNT];
   logic [QW-1:0]  tail_ff [SLOT_COUNT];
   logic [CW-1:0]  cnt_ff  [SLOT_COUNT];

   state_type      state_ff, state_in;
   req_type        req_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff;

   logic           dep_open_ff, dep_open_in;
   logic [7:0]     dep_slot_ff, dep_slot_in;
   logic [31:0]    dep_ip_ff, dep_ip_in;
   logic [15:0]    dep_port_ff, dep_port_in;
   logic [LW-1:0]  dep_off_ff, dep_off_in;
   logic [1:0]     dep_err_ff, dep_err_in;
   logic           rd_open_ff, rd_open_in;
   logic [7:0]     rd_slot_ff, rd_slot_in;
   logic [LW-1:0]  rd_off_ff, rd_off_in;
   logic [LW-1:0]  rd_lim_ff, rd_lim_in;

   logic           accept;
   // read address for the accept cycle
   logic           a_open;
   logic [7:0]     a_slot;
   logic [SW-1:0]  a_idx;
   logic [HAW-1:0] a_entry;
   logic [PAW-1:0] a_paddr;

   // execute cycle write controls
   logic           pay_we, hdr_we, tail_inc, head_inc;
   logic [SW-1:0]  d_idx, r_idx;
   logic [HAW-1:0] d_entry;
   logic [PAW-1:0] d_paddr;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      a_open  = req_data.first || !rd_open_ff;
      a_slot  = a_open ? req_data.slot : rd_slot_ff;
      a_idx   = (32'(a_slot) < SLOT_COUNT) ? a_slot[SW-1:0] : '0;
      a_entry = HAW'(HAW'(a_idx) * HAW'(QUEUE_DEPTH) + HAW'(head_ff[a_idx]));
      a_paddr = PAW'(PAW'(a_entry) * PAW'(MAX_PAYLOAD) + (a_open ? '0 : PAW'(rd_off_ff)));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_rd_ff <= hdr_mem[a_entry];
         pay_rd_ff <= pay_mem[a_paddr];
      end
      if (hdr_we) begin
         hdr_mem[d_entry] <= {dep_ip_in, dep_port_in, dep_off_in};
      end
      if (pay_we) begin
         pay_mem[d_paddr] <= req_ff.data_byte;
      end
   end

   always_comb begin
      logic           op;
      logic           sv;
      logic [LW-1:0]  off;
      logic [LW-1:0]  len;
      logic [LW-1:0]  lim;
      logic [CW-1:0]  cnt_after;

      state_in    = state_ff;
      rsp_in      = rsp_ff;
      dep_open_in = dep_open_ff;
      dep_slot_in = dep_slot_ff;
      dep_ip_in   = dep_ip_ff;
      dep_port_in = dep_port_ff;
      dep_off_in  = dep_off_ff;
      dep_err_in  = dep_err_ff;
      rd_open_in  = rd_open_ff;
      rd_slot_in  = rd_slot_ff;
      rd_off_in   = rd_off_ff;
      rd_lim_in   = rd_lim_ff;
      pay_we      = 1'b0;
      hdr_we      = 1'b0;
      tail_inc    = 1'b0;
      head_inc    = 1'b0;
      op          = 1'b0;
      sv          = 1'b0;
      off         = '0;
      len         = hdr_rd_ff[LW-1:0];
      lim         = '0;
      cnt_after   = '0;
      d_idx       = '0;
      r_idx       = '0;
      d_entry     = '0;
      d_paddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
            rsp_in   = '0;
            case (req_ff.kind)
               KIND_DEPOSIT: begin
                  op = req_ff.first || !dep_open_ff;
                  if (op) begin
                     dep_open_in = 1'b1;
                     dep_slot_in = req_ff.slot;
                     dep_ip_in   = req_ff.src_ip;
                     dep_port_in = req_ff.sender_port;
                     dep_off_in  = '0;
                  end
                  sv    = 32'(dep_slot_in) < SLOT_COUNT;
                  d_idx = sv ? dep_slot_in[SW-1:0] : '0;
                  if (op) begin
                     if (!sv) dep_err_in = ST_BAD_SLOT[1:0];
                     else if (32'(cnt_ff[d_idx]) >= QUEUE_DEPTH) dep_err_in = ST_FULL[1:0];
                     else dep_err_in = ST_OK[1:0];
                  end
                  d_entry = HAW'(HAW'(d_idx) * HAW'(QUEUE_DEPTH) + HAW'(tail_ff[d_idx]));
                  off     = dep_off_in;
                  d_paddr = PAW'(PAW'(d_entry) * PAW'(MAX_PAYLOAD) + PAW'(off));
                  if (req_ff.has_byte) begin
                     if (32'(off) >= MAX_PAYLOAD) begin
                        if (dep_err_in != ST_BAD_SLOT[1:0]) dep_err_in = ST_TOO_LONG[1:0];
                     end else begin
                        pay_we     = (dep_err_in == ST_OK[1:0]);
                        dep_off_in = off + 1'b1;
                     end
                  end
                  cnt_after = sv ? cnt_ff[d_idx] : '0;
                  if (req_ff.last) begin
                     if (dep_err_in == ST_OK[1:0]) begin
                        hdr_we    = 1'b1;
                        tail_inc  = 1'b1;
                        cnt_after = cnt_ff[d_idx] + 1'b1;
                     end
                     dep_open_in = 1'b0;
                  end
                  rsp_in.status  = {1'b0, dep_err_in};
                  rsp_in.pending = 4'(cnt_after);
               end
               KIND_READ: begin
                  op = req_ff.first || !rd_open_ff;
                  if (op) begin
                     rd_open_in = 1'b0;
                     rd_slot_in = req_ff.slot;
                     rd_off_in  = '0;
                     rd_lim_in  = '0;
                  end
                  sv    = 32'(rd_slot_in) < SLOT_COUNT;
                  r_idx = sv ? rd_slot_in[SW-1:0] : '0;
                  if (op && !sv) begin
                     rsp_in.status      = ST_BAD_SLOT;
                     rsp_in.end_of_read = 1'b1;
                  end else if (op && cnt_ff[r_idx] == '0) begin
                     rsp_in.status      = ST_EMPTY;
                     rsp_in.end_of_read = 1'b1;
                  end else begin
                     if (op) begin
                        rd_open_in = 1'b1;
                        rd_lim_in  = (req_ff.max_len < 16'(len)) ? LW'(req_ff.max_len) : len;
                     end
                     lim = rd_lim_in;
                     rsp_in.out_ip   = hdr_rd_ff[HDW-1 -: 32];
                     rsp_in.out_port = hdr_rd_ff[LW +: 16];
                     cnt_after       = cnt_ff[r_idx];
                     if (rd_off_in < lim) begin
                        rsp_in.out_byte   = pay_rd_ff;
                        rsp_in.byte_valid = 1'b1;
                        rd_off_in         = rd_off_in + 1'b1;
                     end
                     if (rd_off_in >= lim) begin
                        rsp_in.end_of_read   = 1'b1;
                        rsp_in.delivered_len = 12'(lim);
                        head_inc             = 1'b1;
                        cnt_after            = cnt_ff[r_idx] - 1'b1;
                        rd_open_in           = 1'b0;
                     end
                     rsp_in.pending = 4'(cnt_after);
                  end
               end
               default: begin
                  sv    = 32'(req_ff.slot) < SLOT_COUNT;
                  r_idx = sv ? req_ff.slot[SW-1:0] : '0;
                  rsp_in.status  = sv ? ST_OK : ST_BAD_SLOT;
                  rsp_in.pending = sv ? 4'(cnt_ff[r_idx]) : 4'd0;
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dep_open_ff  <= 1'b0;
         dep_slot_ff  <= '0;
         dep_ip_ff    <= '0;
         dep_port_ff  <= '0;
         dep_off_ff   <= '0;
         dep_err_ff   <= '0;
         rd_open_ff   <= 1'b0;
         rd_slot_ff   <= '0;
         rd_off_ff    <= '0;
         rd_lim_ff    <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         state_ff    <= state_in;
         dep_open_ff <= dep_open_in;
         dep_slot_ff <= dep_slot_in;
         dep_ip_ff   <= dep_ip_in;
         dep_port_ff <= dep_port_in;
         dep_off_ff  <= dep_off_in;
         dep_err_ff  <= dep_err_in;
         rd_open_ff  <= rd_open_in;
         rd_slot_ff  <= rd_slot_in;
         rd_off_ff   <= rd_off_in;
         rd_lim_ff   <= rd_lim_in;
         if (state_ff == S_EXEC) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (tail_inc) begin
            tail_ff[d_idx] <= (32'(tail_ff[d_idx]) == QUEUE_DEPTH - 1) ? '0
                              : tail_ff[d_idx] + 1'b1;
            cnt_ff[d_idx]  <= cnt_ff[d_idx] + 1'b1;
         end
         if (head_inc) begin
            head_ff[r_idx] <= (32'(head_ff[r_idx]) == QUEUE_DEPTH - 1) ? '0
                              : head_ff[r_idx] + 1'b1;
            cnt_ff[r_idx]  <= cnt_ff[r_idx] - 1'b1;
         end
      end
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   a_exec_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EXEC |=> state_ff == S_IDLE)
      else $error("execute lasted more than one cycle");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EXEC)
      else $error("word shown without execute");

   a_len_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.end_of_read |-> rsp_ff.delivered_len == 12'd0)
      else $error("delivered length outside end of read");

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      !(tail_inc && head_inc))
      else $error("push and pop in one word");

endmodule
